[rtl/cbf_pkg.sv]
// Shared types, constants and lerp arithmetic for the cubic Bezier flattener.
package cbf_pkg;

	localparam int COORD_W = 24;           // coordinate, 8 fraction bits
	localparam int IN_W    = 16;           // whole-pixel input coordinate
	localparam int T_W     = 17;           // t, 16 fraction bits, up to 1.0
	localparam int PROD_W  = 43;           // (b - a) * t
	localparam int IDX_W   = 6;            // sample counter, enough for 63 segments
	localparam int OUT_IDX_W = 5;          // width of the point_index port

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t p0x;
		coord_t p0y;
		coord_t p1x;
		coord_t p1y;
		coord_t p2x;
		coord_t p2y;
		coord_t p3x;
		coord_t p3y;
	} curve_t;

	// Sideband that travels next to the datapath pipeline.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             last;
	} ctl_t;

	// First half of a lerp: (b - a) * t.
	function automatic logic signed [PROD_W-1:0] lerp_mul(input coord_t a, input coord_t b,
		input logic [T_W-1:0] t);
		logic signed [COORD_W:0] d;
		begin
			d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
			return $signed(d) * $signed({1'b0, t});
		end
	endfunction

	// Second half of a lerp: a + ((prod + 0.5) >>> 16). The result always lies
	// between a and b, so the low coordinate bits are exact.
	function automatic coord_t lerp_fin(input coord_t a, input logic signed [PROD_W-1:0] prod);
		logic signed [PROD_W-1:0] rnd;
		begin
			rnd = prod + PROD_W'(32768);
			return a + coord_t'(rnd[COORD_W+15:16]);
		end
	endfunction

endpackage

[rtl/cbf_front.sv]
// Front end: takes curve commands, widens them to fixed point and queues them.
module cbf_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [cbf_pkg::IN_W-1:0]    start_x,
	input  logic signed [cbf_pkg::IN_W-1:0]    start_y,
	input  logic signed [cbf_pkg::IN_W-1:0]    ctrl_a_x,
	input  logic signed [cbf_pkg::IN_W-1:0]    ctrl_a_y,
	input  logic signed [cbf_pkg::IN_W-1:0]    ctrl_b_x,
	input  logic signed [cbf_pkg::IN_W-1:0]    ctrl_b_y,
	input  logic signed [cbf_pkg::IN_W-1:0]    end_x,
	input  logic signed [cbf_pkg::IN_W-1:0]    end_y,
	output logic                               head_valid,
	output cbf_pkg::curve_t                    head,
	input  logic                               pop
);

	cbf_pkg::curve_t entry_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;
	logic            push;
	cbf_pkg::curve_t widened;

	// Whole pixels gain eight zero fraction bits.
	always_comb begin
		widened.p0x = {start_x,  8'h00};
		widened.p0y = {start_y,  8'h00};
		widened.p1x = {ctrl_a_x, 8'h00};
		widened.p1y = {ctrl_a_y, 8'h00};
		widened.p2x = {ctrl_b_x, 8'h00};
		widened.p2y = {ctrl_b_y, 8'h00};
		widened.p3x = {end_x,    8'h00};
		widened.p3y = {end_y,    8'h00};
	end

	assign busy       = count_q[1];
	assign push       = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= widened;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/cbf_eval.sv]
// Six-stage de Casteljau pipeline for one coordinate of a cubic curve.
module cbf_eval (
	input  logic                       clk,
	input  cbf_pkg::coord_t            p0,
	input  cbf_pkg::coord_t            p1,
	input  cbf_pkg::coord_t            p2,
	input  cbf_pkg::coord_t            p3,
	input  logic [cbf_pkg::T_W-1:0]    t,
	output cbf_pkg::coord_t            point
);

	logic signed [cbf_pkg::PROD_W-1:0] m0_s1, m1_s1, m2_s1;
	cbf_pkg::coord_t                   p0_s1, p1_s1, p2_s1;
	logic [cbf_pkg::T_W-1:0]           t_s1, t_s2, t_s3, t_s4;
	cbf_pkg::coord_t                   q0_s2, q1_s2, q2_s2;
	logic signed [cbf_pkg::PROD_W-1:0] m0_s3, m1_s3;
	cbf_pkg::coord_t                   q0_s3, q1_s3;
	cbf_pkg::coord_t                   r0_s4, r1_s4;
	logic signed [cbf_pkg::PROD_W-1:0] m_s5;
	cbf_pkg::coord_t                   r0_s5;
	cbf_pkg::coord_t                   point_s6;

	always_ff @(posedge clk) begin
		// Level one: three products, then three lerps.
		m0_s1 <= cbf_pkg::lerp_mul(p0, p1, t);
		m1_s1 <= cbf_pkg::lerp_mul(p1, p2, t);
		m2_s1 <= cbf_pkg::lerp_mul(p2, p3, t);
		p0_s1 <= p0;
		p1_s1 <= p1;
		p2_s1 <= p2;
		t_s1  <= t;

		q0_s2 <= cbf_pkg::lerp_fin(p0_s1, m0_s1);
		q1_s2 <= cbf_pkg::lerp_fin(p1_s1, m1_s1);
		q2_s2 <= cbf_pkg::lerp_fin(p2_s1, m2_s1);
		t_s2  <= t_s1;

		// Level two.
		m0_s3 <= cbf_pkg::lerp_mul(q0_s2, q1_s2, t_s2);
		m1_s3 <= cbf_pkg::lerp_mul(q1_s2, q2_s2, t_s2);
		q0_s3 <= q0_s2;
		q1_s3 <= q1_s2;
		t_s3  <= t_s2;

		r0_s4 <= cbf_pkg::lerp_fin(q0_s3, m0_s3);
		r1_s4 <= cbf_pkg::lerp_fin(q1_s3, m1_s3);
		t_s4  <= t_s3;

		// Final lerp.
		m_s5  <= cbf_pkg::lerp_mul(r0_s4, r1_s4, t_s4);
		r0_s5 <= r0_s4;

		point_s6 <= cbf_pkg::lerp_fin(r0_s5, m_s5);
	end

	assign point = point_s6;

endmodule

[rtl/cbf_back.sv]
// Back end: steps t over each queued curve and runs both coordinate pipelines.
module cbf_back #(
	parameter int SEGMENTS = 25
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  cbf_pkg::curve_t                      head,
	output logic                                 pop,
	output logic                                 valid,
	output logic [cbf_pkg::OUT_IDX_W-1:0]        point_index,
	output cbf_pkg::coord_t                      point_x,
	output cbf_pkg::coord_t                      point_y,
	output logic                                 last_point
);

	// t_k = (k*65536 + SEGMENTS/2) / SEGMENTS, kept as quotient and remainder
	// and advanced by 65536/SEGMENTS each step with one carry correction.
	localparam int Q_STEP = 65536 / SEGMENTS;
	localparam int R_STEP = 65536 % SEGMENTS;
	localparam int R_INIT = SEGMENTS / 2;
	localparam int RW     = (SEGMENTS > 1) ? $clog2(2 * SEGMENTS) : 1;

	cbf_pkg::curve_t                 curve_q;
	logic                            run_q;
	logic [cbf_pkg::IDX_W-1:0]       k_q;
	logic [cbf_pkg::T_W-1:0]         tq_q;
	logic [RW-1:0]                   tr_q;
	logic [RW-1:0]                   r_sum;
	logic                            r_carry;
	logic                            at_last;
	cbf_pkg::ctl_t                   ctl_s0, ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	assign at_last = (k_q == cbf_pkg::IDX_W'(SEGMENTS));
	assign pop     = head_valid && (!run_q || at_last);
	assign r_sum   = tr_q + RW'(R_STEP);
	assign r_carry = (r_sum >= RW'(SEGMENTS));

	always_ff @(posedge clk) begin
		if (pop) begin
			curve_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			k_q   <= '0;
			tq_q  <= '0;
			tr_q  <= '0;
		end else if (pop) begin
			run_q <= 1'b1;
			k_q   <= '0;
			tq_q  <= '0;
			tr_q  <= RW'(R_INIT);
		end else if (run_q && at_last) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			k_q  <= k_q + cbf_pkg::IDX_W'(1);
			tq_q <= tq_q + cbf_pkg::T_W'(Q_STEP) + cbf_pkg::T_W'(r_carry);
			tr_q <= r_carry ? (r_sum - RW'(SEGMENTS)) : r_sum;
		end
	end

	always_comb begin
		ctl_s0.valid = run_q;
		ctl_s0.idx   = k_q;
		ctl_s0.last  = at_last;
	end

	// Sideband delay matching the six datapath stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	cbf_eval u_eval_x (
		.clk   (clk),
		.p0    (curve_q.p0x),
		.p1    (curve_q.p1x),
		.p2    (curve_q.p2x),
		.p3    (curve_q.p3x),
		.t     (tq_q),
		.point (point_x)
	);

	cbf_eval u_eval_y (
		.clk   (clk),
		.p0    (curve_q.p0y),
		.p1    (curve_q.p1y),
		.p2    (curve_q.p2y),
		.p3    (curve_q.p3y),
		.t     (tq_q),
		.point (point_y)
	);

	assign valid       = ctl_s6.valid;
	assign point_index = ctl_s6.idx[cbf_pkg::OUT_IDX_W-1:0];
	assign last_point  = ctl_s6.last;

endmodule

[rtl/cubic_bezier_flattener.sv]
// Top level of the cubic Bezier flattener: front queue plus evaluation back end.
//
// A curve command is transferred on a rising edge where start is high and busy
// is low; the eight signed whole-pixel coordinates are sampled at that edge.
// The block answers with SEGMENTS+1 points, k = 0 .. SEGMENTS in order, each
// shown for exactly one cycle with valid high. point_x and point_y carry 8
// fraction bits, point_index is k (low five bits), and last_point marks the
// point at t equal to one. The receiver takes every point; it cannot stall.
//
// With the block idle, point 0 travels from the transfer edge through the
// two-entry command queue, the back end's curve and t registers, which it
// loads as it pops the curve for its evaluator, and the de Casteljau pipeline
// (three lerp levels, each a registered multiply followed by a registered
// round and add).
// Throughput: one point per cycle, and curves follow each other with no gap
// while the next curve is already queued. The evaluator's single point per
// cycle sets that rate. Busy rises only while two curves wait in the queue.
// Reset clears the queue, the sequencer and the output strobe; no point is
// emitted until a new curve is transferred.
module cubic_bezier_flattener #(
	parameter int SEGMENTS = 25
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [cbf_pkg::IN_W-1:0]      start_x,
	input  logic signed [cbf_pkg::IN_W-1:0]      start_y,
	input  logic signed [cbf_pkg::IN_W-1:0]      ctrl_a_x,
	input  logic signed [cbf_pkg::IN_W-1:0]      ctrl_a_y,
	input  logic signed [cbf_pkg::IN_W-1:0]      ctrl_b_x,
	input  logic signed [cbf_pkg::IN_W-1:0]      ctrl_b_y,
	input  logic signed [cbf_pkg::IN_W-1:0]      end_x,
	input  logic signed [cbf_pkg::IN_W-1:0]      end_y,
	output logic                                 valid,
	output logic [cbf_pkg::OUT_IDX_W-1:0]        point_index,
	output logic signed [cbf_pkg::COORD_W-1:0]   point_x,
	output logic signed [cbf_pkg::COORD_W-1:0]   point_y,
	output logic                                 last_point
);

	logic            head_valid;
	cbf_pkg::curve_t head;
	logic            pop;

	// The front end owns the handshake and holds up to two pending curves.
	cbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.start_x    (start_x),
		.start_y    (start_y),
		.ctrl_a_x   (ctrl_a_x),
		.ctrl_a_y   (ctrl_a_y),
		.ctrl_b_x   (ctrl_b_x),
		.ctrl_b_y   (ctrl_b_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// The back end pops the next queued curve in the same cycle it issues the
	// last point of the current one, so queued curves follow with no gap.
	cbf_back #(
		.SEGMENTS (SEGMENTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.valid       (valid),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.last_point  (last_point)
	);

endmodule
